// ===== design/http_get_request_validator_core_defines.svh =====
// Assertion macros used by the request validator top level.
`ifndef HTTP_GET_REQUEST_VALIDATOR_CORE_DEFINES_SVH
`define HTTP_GET_REQUEST_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on aclk while aresetn is high.
`define HGV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("request validator check failed");

// Next-cycle implication, checked on aclk while aresetn is high.
`define HGV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("request validator check failed");

`endif

// ===== design/hgv_pkg.sv =====
// Shared types and codes of the HTTP GET request validator.
package hgv_pkg;

    // Result kinds
    localparam logic KIND_PATH    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes
    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_NOHOST    = 2'd2;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] path_byte;
        logic [1:0] status;
        logic       last_result;
    } hgv_result_t;

    // Results caused by one input item, in output order
    typedef struct packed {
        logic [1:0]  count;
        hgv_result_t first;
        hgv_result_t second;
    } hgv_step_t;

endpackage

// ===== design/hgv_parser.sv =====
// Request parser state and the per-byte next-state and result logic.
module hgv_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_request,
    output hgv_pkg::hgv_step_t step
);

    localparam logic [3:0] PH_WAIT1  = 4'd0;
    localparam logic [3:0] PH_PRE1   = 4'd1;
    localparam logic [3:0] PH_W1     = 4'd2;
    localparam logic [3:0] PH_PRE2   = 4'd3;
    localparam logic [3:0] PH_W2     = 4'd4;
    localparam logic [3:0] PH_PRE3   = 4'd5;
    localparam logic [3:0] PH_W3     = 4'd6;
    localparam logic [3:0] PH_REST1  = 4'd7;
    localparam logic [3:0] PH_LSTART = 4'd8;
    localparam logic [3:0] PH_LINE   = 4'd9;
    localparam logic [3:0] PH_DONE   = 4'd10;

    localparam logic WORD_GET = 1'b0;
    localparam logic WORD_VER = 1'b1;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [3:0] LEN_GET    = 4'd3;
    localparam logic [3:0] LEN_VER    = 4'd8;
    localparam logic [2:0] LEN_HOST   = 3'd6;
    localparam logic [3:0] INDEX_MAX  = 4'd15;

    logic [3:0] phase_reg, phase_next;
    logic [3:0] match_index_reg, match_index_next;
    logic       word_matches_reg, word_matches_next;
    logic [2:0] line_length_reg, line_length_next;
    logic       verdict_given_reg, verdict_given_next;

    logic       path_v;
    logic       verd_v;
    logic [1:0] verd_st;
    logic       brk;
    logic       sp;

    // Character of the method or version word at a position
    function automatic logic [7:0] word_char(input logic sel, input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (sel == WORD_GET) begin
            unique case (idx)
                4'd0:    c = "G";
                4'd1:    c = "E";
                4'd2:    c = "T";
                default: c = 8'h00;
            endcase
        end else begin
            unique case (idx)
                4'd0:    c = "H";
                4'd1:    c = "T";
                4'd2:    c = "T";
                4'd3:    c = "P";
                4'd4:    c = "/";
                4'd5:    c = "1";
                4'd6:    c = ".";
                4'd7:    c = "1";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic logic [3:0] word_len(input logic sel);
        return (sel == WORD_GET) ? LEN_GET : LEN_VER;
    endfunction

    function automatic logic [7:0] host_char(input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            3'd0:    c = "H";
            3'd1:    c = "o";
            3'd2:    c = "s";
            3'd3:    c = "t";
            3'd4:    c = ":";
            3'd5:    c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // One matching step: returns {next index, next match flag}
    function automatic logic [4:0] match_step(input logic sel, input logic [3:0] idx,
                                              input logic wm, input logic [7:0] b);
        logic       w;
        logic [3:0] i;
        w = wm;
        i = idx;
        if (idx >= word_len(sel) || word_char(sel, idx) != b) begin
            w = 1'b0;
        end
        if (idx < INDEX_MAX) begin
            i = idx + 4'd1;
        end
        return {i, w};
    endfunction

    // Verdict when the request text ends without one
    function automatic logic [1:0] end_status(input logic [3:0] ph, input logic [3:0] mi,
                                              input logic wm);
        logic [1:0] s;
        s = hgv_pkg::ST_MALFORMED;
        if (ph == PH_W3) begin
            s = (wm && mi == LEN_VER) ? hgv_pkg::ST_NOHOST : hgv_pkg::ST_MALFORMED;
        end else if (ph == PH_REST1 || ph == PH_LSTART || ph == PH_LINE) begin
            s = hgv_pkg::ST_NOHOST;
        end
        return s;
    endfunction

    // Advance the parser by one byte
    always_comb begin
        phase_next         = phase_reg;
        match_index_next   = match_index_reg;
        word_matches_next  = word_matches_reg;
        line_length_next   = line_length_reg;
        verdict_given_next = verdict_given_reg;
        path_v  = 1'b0;
        verd_v  = 1'b0;
        verd_st = hgv_pkg::ST_VALID;
        brk = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
        sp  = (data_byte == CHAR_SP);

        if (!verdict_given_reg) begin
            if (data_byte == CHAR_NUL) begin
                verd_v  = 1'b1;
                verd_st = end_status(phase_next, match_index_next, word_matches_next);
            end else begin
                unique case (phase_reg)
                    PH_WAIT1: begin
                        if (sp) begin
                            phase_next = PH_PRE1;
                        end else if (!brk) begin
                            {match_index_next, word_matches_next} =
                                match_step(WORD_GET, 4'd0, 1'b1, data_byte);
                            phase_next = PH_W1;
                        end
                    end
                    PH_PRE1: begin
                        if (brk) begin
                            verd_v  = 1'b1;
                            verd_st = hgv_pkg::ST_MALFORMED;
                        end else if (!sp) begin
                            {match_index_next, word_matches_next} =
                                match_step(WORD_GET, 4'd0, 1'b1, data_byte);
                            phase_next = PH_W1;
                        end
                    end
                    PH_W1: begin
                        if (brk) begin
                            verd_v  = 1'b1;
                            verd_st = hgv_pkg::ST_MALFORMED;
                        end else if (sp) begin
                            if (word_matches_reg && match_index_reg == LEN_GET) begin
                                phase_next = PH_PRE2;
                            end else begin
                                verd_v  = 1'b1;
                                verd_st = hgv_pkg::ST_MALFORMED;
                            end
                        end else begin
                            {match_index_next, word_matches_next} =
                                match_step(WORD_GET, match_index_reg, word_matches_reg,
                                           data_byte);
                        end
                    end
                    PH_PRE2: begin
                        if (brk) begin
                            verd_v  = 1'b1;
                            verd_st = hgv_pkg::ST_MALFORMED;
                        end else if (!sp) begin
                            path_v     = 1'b1;
                            phase_next = PH_W2;
                        end
                    end
                    PH_W2: begin
                        if (brk) begin
                            verd_v  = 1'b1;
                            verd_st = hgv_pkg::ST_MALFORMED;
                        end else if (sp) begin
                            phase_next = PH_PRE3;
                        end else begin
                            path_v = 1'b1;
                        end
                    end
                    PH_PRE3: begin
                        if (brk) begin
                            verd_v  = 1'b1;
                            verd_st = hgv_pkg::ST_MALFORMED;
                        end else if (!sp) begin
                            {match_index_next, word_matches_next} =
                                match_step(WORD_VER, 4'd0, 1'b1, data_byte);
                            phase_next = PH_W3;
                        end
                    end
                    PH_W3: begin
                        if (brk || sp) begin
                            if (!(word_matches_reg && match_index_reg == LEN_VER)) begin
                                verd_v  = 1'b1;
                                verd_st = hgv_pkg::ST_MALFORMED;
                            end else begin
                                phase_next = brk ? PH_LSTART : PH_REST1;
                            end
                        end else begin
                            {match_index_next, word_matches_next} =
                                match_step(WORD_VER, match_index_reg, word_matches_reg,
                                           data_byte);
                        end
                    end
                    PH_REST1: begin
                        if (brk) begin
                            phase_next = PH_LSTART;
                        end
                    end
                    PH_LSTART: begin
                        if (!brk) begin
                            word_matches_next = (data_byte == host_char(3'd0));
                            line_length_next  = 3'd1;
                            phase_next        = PH_LINE;
                        end
                    end
                    PH_LINE: begin
                        if (brk) begin
                            phase_next = PH_LSTART;
                        end else if (line_length_reg < LEN_HOST) begin
                            if (host_char(line_length_reg) != data_byte) begin
                                word_matches_next = 1'b0;
                            end
                            line_length_next = line_length_reg + 3'd1;
                        end else if (word_matches_reg) begin
                            verd_v  = 1'b1;
                            verd_st = hgv_pkg::ST_VALID;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // End of request without a verdict yet: judge the state left by this byte
            if (!verd_v && end_of_request) begin
                verd_v  = 1'b1;
                verd_st = end_status(phase_next, match_index_next, word_matches_next);
            end
            if (verd_v) begin
                verdict_given_next = 1'b1;
                phase_next         = PH_DONE;
            end
        end

        // Rearm for the next request
        if (end_of_request) begin
            phase_next         = PH_WAIT1;
            match_index_next   = 4'd0;
            word_matches_next  = 1'b1;
            line_length_next   = 3'd0;
            verdict_given_next = 1'b0;
        end
    end

    // Order the results of this byte: path byte first, verdict last
    always_comb begin
        step.count  = {1'b0, path_v} + {1'b0, verd_v};
        step.first  = '0;
        step.second = '0;
        if (path_v) begin
            step.first.kind        = hgv_pkg::KIND_PATH;
            step.first.path_byte   = data_byte;
            step.first.status      = hgv_pkg::ST_VALID;
            step.first.last_result = !verd_v;
            if (verd_v) begin
                step.second.kind        = hgv_pkg::KIND_VERDICT;
                step.second.status      = verd_st;
                step.second.last_result = 1'b1;
            end
        end else if (verd_v) begin
            step.first.kind        = hgv_pkg::KIND_VERDICT;
            step.first.status      = verd_st;
            step.first.last_result = 1'b1;
        end
    end

    // Hold parser state, advance on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_WAIT1;
            match_index_reg   <= 4'd0;
            word_matches_reg  <= 1'b1;
            line_length_reg   <= 3'd0;
            verdict_given_reg <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            match_index_reg   <= match_index_next;
            word_matches_reg  <= word_matches_next;
            line_length_reg   <= line_length_next;
            verdict_given_reg <= verdict_given_next;
        end
    end

endmodule

// ===== design/hgv_out_queue.sv =====
// Three-entry result queue: takes up to two results per cycle while it has room, drives one.
module hgv_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hgv_pkg::hgv_step_t  step,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output hgv_pkg::hgv_result_t out_item
);

    hgv_pkg::hgv_result_t q0_reg, q0_next;
    hgv_pkg::hgv_result_t q1_reg, q1_next;
    hgv_pkg::hgv_result_t q2_reg, q2_next;
    logic [1:0] count_reg, count_next;

    logic       pop;
    logic [1:0] n_push;
    logic [1:0] base;
    logic [1:0] fill;

    assign out_valid = (count_reg != 2'd0);
    assign out_item  = q0_reg;
    // Room for two more results after this cycle
    assign in_ready  = (count_reg <= 2'd1);
    assign pop       = out_valid && out_ready;
    assign n_push    = push ? step.count : 2'd0;
    assign base      = count_reg - {1'b0, pop};
    // At most three entries: a push only happens with one or none left
    assign fill      = base + n_push;

    // Shift out the taken head, then append new results behind what remains
    always_comb begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        count_next = fill;

        if (base > 2'd0) begin
            q0_next = pop ? q1_reg : q0_reg;
        end else if (n_push != 2'd0) begin
            q0_next = step.first;
        end

        if (base > 2'd1) begin
            q1_next = pop ? q2_reg : q1_reg;
        end else if (base == 2'd1 && n_push != 2'd0) begin
            q1_next = step.first;
        end else if (base == 2'd0 && n_push == 2'd2) begin
            q1_next = step.second;
        end

        if (base == 2'd2 && n_push != 2'd0) begin
            q2_next = step.first;
        end else if (base == 2'd1 && n_push == 2'd2) begin
            q2_next = step.second;
        end
    end

    // Hold queue contents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        q2_reg <= q2_next;
    end

endmodule

// ===== design/http_get_request_validator_core.sv =====
// Top level of the HTTP GET request validator.
//
// Input channel (s_): one request byte per item, with s_end_of_request on the
// final byte of a request. Result channel (m_): path bytes (m_kind 0) as they
// arrive, then one verdict (m_kind 1) with m_status 0 valid, 1 malformed
// request line, 2 host line missing. m_last_result marks the last result that
// an input item caused.
// A result enters the result queue register when its byte is accepted and is
// offered on m_ behind any results still waiting in the queue.
// Throughput: one byte per cycle while s_ready is high; the byte-parsing logic
// sits between the input handshake and a three-entry result queue. A byte that
// yields both a path byte and a verdict (end of request) leaves at least two
// results queued, so s_ready drops while the queue drains.
// Stall: while m_ready is low, s_ready stays high until two results are
// waiting; nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the queue and returns the
// parser to waiting for the first line of a request.
`include "http_get_request_validator_core_defines.svh"

module http_get_request_validator_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_request,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_path_byte,
    output logic [1:0] m_status,
    output logic       m_last_result
);

    logic                 accept;
    hgv_pkg::hgv_step_t   step;
    hgv_pkg::hgv_result_t head;

    assign accept = s_valid && s_ready;

    // Parse each accepted byte
    hgv_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_data_byte),
        .end_of_request (s_end_of_request),
        .step           (step)
    );

    // Queue the results toward the receiver
    hgv_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .step      (step),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (head)
    );

    assign m_kind        = head.kind;
    assign m_path_byte   = head.path_byte;
    assign m_status      = head.status;
    assign m_last_result = head.last_result;

    // A verdict always closes the results of its byte
    `HGV_ASSERT_IMP(a_verdict_last, m_valid && m_kind == hgv_pkg::KIND_VERDICT, m_last_result)
    // Path results carry no verdict code
    `HGV_ASSERT_IMP(a_path_status, m_valid && m_kind == hgv_pkg::KIND_PATH, m_status == hgv_pkg::ST_VALID)
    // Verdicts carry no path byte
    `HGV_ASSERT_IMP(a_verdict_byte, m_valid && m_kind == hgv_pkg::KIND_VERDICT, m_path_byte == 8'd0)
    // Hold a stalled result item steady until it is taken
    `HGV_ASSERT_NXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(head))

endmodule
